// ===== rtl/nlvm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nlvm_pkg: shared types and constants of the noise LFSR voice mixer
// Level codes, field widths, noise reset values and the per-voice level rule.
// ----------------------------------------------------------------------------
package nlvm_pkg;

	localparam int unsigned NUM_VOICES = 3;
	localparam int unsigned LEVEL_W    = 3;
	localparam int unsigned SUM_W      = 5;   // four levels of at most 4 each
	localparam int unsigned VOL_W      = 4;
	localparam int unsigned PROD_W     = 8;   // 16 * 15 = 240
	localparam int unsigned PWM_W      = 9;
	localparam int unsigned PCM_W      = 15;
	localparam int unsigned BIAS_W     = 8;
	localparam int unsigned LFSR_W     = 16;
	localparam int unsigned SHIFT_W    = 8;

	localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 3'd4;
	localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 3'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_IDLE = 3'd1;

	localparam logic [LFSR_W-1:0]  LFSR_RESET  = 16'hFFFF;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 8'h00;

	typedef logic [LEVEL_W-1:0] level_t;

	// Control of the noise generator for one word.
	typedef struct packed {
		logic step;     // clock the LFSR with this word
		logic enable;   // noise channel enable
	} noise_ctl_t;

	// A disabled channel sits at the idle level; an enabled one follows its bit.
	function automatic level_t level_of(input logic enabled, input logic bit_val);
		level_t lvl;
		if (!enabled) begin
			lvl = LEVEL_IDLE;
		end else if (bit_val) begin
			lvl = LEVEL_HIGH;
		end else begin
			lvl = LEVEL_LOW;
		end
		return lvl;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/noise_lfsr_voice_mixer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// noise_lfsr_voice_mixer: noise generator and four-channel volume mixer
// Mixes three tone voices with an LFSR noise channel and scales by volume.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------------
//  in       in_valid / in_stall  voice_enables, voice_bits, noise_step,
//                                noise_enable, volume
//  out      out_valid/out_stall  pwm_level, pcm_sample
//  cfg      cfg_valid/cfg_ready  cfg_data (pwm_bias)
//
// Each accepted word lands in the input register; as it moves on to the
// result register, the noise generator steps and the mix is formed, and the
// result register drives the output. One word per cycle is sustained while
// out_stall is low. The input side stalls only when the input register is
// full and the result register is held by out_stall. Reset clears both valid
// flags, loads the LFSR with all ones, clears the noise shift register, sets
// the noise level to the idle level and clears pwm_bias. cfg_ready is always
// high.
// ----------------------------------------------------------------------------
module noise_lfsr_voice_mixer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,

	input  wire logic                               in_valid,
	output      logic                               in_stall,
	input  wire logic [nlvm_pkg::NUM_VOICES-1:0]    voice_enables,
	input  wire logic [nlvm_pkg::NUM_VOICES-1:0]    voice_bits,
	input  wire logic                               noise_step,
	input  wire logic                               noise_enable,
	input  wire logic [nlvm_pkg::VOL_W-1:0]         volume,

	output      logic                               out_valid,
	input  wire logic                               out_stall,
	output      logic [nlvm_pkg::PWM_W-1:0]         pwm_level,
	output      logic signed [nlvm_pkg::PCM_W-1:0]  pcm_sample,

	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [nlvm_pkg::BIAS_W-1:0]        cfg_data
);
	import nlvm_pkg::*;

	// Input register.
	logic                  valid_s1;
	logic [NUM_VOICES-1:0] enables_s1;
	logic [NUM_VOICES-1:0] bits_s1;
	logic                  step_s1;
	logic                  nen_s1;
	logic [VOL_W-1:0]      vol_s1;

	// Result register and bias register.
	logic                  out_valid_q;
	logic [PWM_W-1:0]      pwm_q;
	logic [PCM_W-1:0]      pcm_q;
	logic [BIAS_W-1:0]     bias_q;

	logic                  advance;
	logic                  in_accept;
	noise_ctl_t            noise_ctl;
	level_t                noise_level;
	logic [SUM_W-1:0]      sum;
	logic [PROD_W-1:0]     prod;
	logic [PWM_W-1:0]      pwm_d;
	logic [PCM_W-1:0]      pcm_d;

	// The word in the input register moves on whenever the result register is
	// empty or is being taken this cycle.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// The noise generator steps only as its word leaves the input register.
	assign noise_ctl = '{step: advance && step_s1, enable: nen_s1};

	nlvm_noise u_noise (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (noise_ctl),
		.level_next (noise_level)
	);

	// Mix with the noise level after this word's step.
	always_comb begin
		sum = SUM_W'(noise_level);
		for (int i = 0; i < NUM_VOICES; i++) begin
			sum = sum + SUM_W'(level_of(enables_s1[i], bits_s1[i]));
		end
		prod  = PROD_W'(sum * vol_s1);
		pwm_d = PWM_W'(prod) + PWM_W'(bias_q);
		pcm_d = PCM_W'({prod, 6'b0}) - PCM_W'({vol_s1, 8'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			bias_q      <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				bias_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			enables_s1 <= voice_enables;
			bits_s1    <= voice_bits;
			step_s1    <= noise_step;
			nen_s1     <= noise_enable;
			vol_s1     <= volume;
		end
		if (advance) begin
			pwm_q <= pwm_d;
			pcm_q <= pcm_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign pwm_level  = pwm_q;
	assign pcm_sample = signed'(pcm_q);

endmodule
`default_nettype wire

// ===== rtl/nlvm_noise.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nlvm_noise: noise LFSR, noise shift register and noise level
// Gives the noise level that holds after the current word's step.
// ----------------------------------------------------------------------------
module nlvm_noise (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire nlvm_pkg::noise_ctl_t ctl,
	output nlvm_pkg::level_t         level_next
);
	import nlvm_pkg::*;

	logic [LFSR_W-1:0]  lfsr_q;
	logic [SHIFT_W-1:0] shift_q;
	level_t             level_q;

	logic               feedback;
	logic               new_bit;
	logic               rise;
	logic               shift_in;
	logic [LFSR_W-1:0]  lfsr_d;
	logic [SHIFT_W-1:0] shift_d;

	always_comb begin
		feedback = lfsr_q[3] ^ lfsr_q[12] ^ lfsr_q[14] ^ lfsr_q[15];
		new_bit  = ctl.enable ? feedback : 1'b1;
		// The shift register moves only when the LFSR's low bit goes from 0 to 1.
		rise     = ctl.step && new_bit && !lfsr_q[0];
		shift_in = !shift_q[SHIFT_W-1] && ctl.enable;
		lfsr_d   = ctl.step ? {lfsr_q[LFSR_W-2:0], new_bit} : lfsr_q;
		shift_d  = rise ? {shift_q[SHIFT_W-2:0], shift_in} : shift_q;
		level_next = rise ? level_of(ctl.enable, shift_in) : level_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q  <= LFSR_RESET;
			shift_q <= SHIFT_RESET;
			level_q <= LEVEL_IDLE;
		end else begin
			lfsr_q  <= lfsr_d;
			shift_q <= shift_d;
			level_q <= level_next;
		end
	end

endmodule
`default_nettype wire
